/* hw/rtl/mlrp_pkg.sv */
// Shared types and constants of the mail LIST reply parser.
// No dependencies; every other file of the block but mlrp_fifo imports this package.
package mlrp_pkg;

	// Width of every numeric result field and of the slot register
	localparam int OUT_W   = 32;
	localparam int SLOTS_W = 16;

	// Queue depths, powers of two, at least two
	localparam int ITEM_DEPTH = 4;
	localparam int REC_DEPTH  = 4;

	// Characters the parser looks for
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [3:0] {
		PH_SEEK_O  = 4'd0,
		PH_SEEK_K  = 4'd1,
		PH_SKIP    = 4'd2,
		PH_COUNT   = 4'd3,
		PH_SEEK_CR = 4'd4,
		PH_SEEK_LF = 4'd5,
		PH_NUMBER  = 4'd6,
		PH_SIZE    = 4'd7,
		PH_SIZE_LF = 4'd8,
		PH_DONE    = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		REC_COUNT = 2'd0,
		REC_ENTRY = 2'd1,
		REC_END   = 2'd2
	} rec_kind_t;

	// Classified input byte
	typedef struct packed {
		logic       is_digit;
		logic [3:0] digit;
		logic       is_space;
		logic       is_cr;
		logic       is_lf;
		logic       is_o;
		logic       is_k;
		logic       is_end;
	} item_t;

	// One result record
	typedef struct packed {
		rec_kind_t        kind;
		logic [OUT_W-1:0] msg_number;
		logic [OUT_W-1:0] value;
		logic [OUT_W-1:0] total_size;
		logic             slot_valid;
		logic             found_ok;
		logic             last_record;
	} rec_t;

endpackage

/* hw/rtl/mlrp_fifo.sv */
// Small register queue with up to two writes and one read per cycle.
// Generic over the entry type; no package dependency.
module mlrp_fifo #(
	parameter type entry_t = logic,
	parameter int  DEPTH   = 4,
	localparam int PW      = $clog2(DEPTH),
	localparam int CW      = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    wr_cnt,
	input  entry_t        wr_data0,
	input  entry_t        wr_data1,
	input  logic          rd_en,
	output entry_t        rd_data,
	output logic [CW-1:0] count
);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(wr_cnt);
			rd_ptr_q <= rd_ptr_q + PW'(rd_en);
			count_q  <= count_q + CW'(wr_cnt) - CW'(rd_en);
		end
	end

	// Store incoming entries, second one behind the first
	always_ff @(posedge clk) begin
		if (wr_cnt[0] | wr_cnt[1]) begin
			mem_q[wr_ptr_q] <= wr_data0;
		end
		if (wr_cnt[1]) begin
			mem_q[wr_ptr_q + PW'(1)] <= wr_data1;
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign count   = count_q;

endmodule

/* hw/rtl/mlrp_front.sv */
// Front end: decodes one reply byte into the character classes the parser uses.
// Depends on mlrp_pkg.
module mlrp_front import mlrp_pkg::*; (
	input  logic [7:0] reply_byte,
	input  logic       end_of_reply,
	output item_t      item
);

	logic is_digit;

	assign is_digit = (reply_byte >= CH_ZERO) && (reply_byte <= CH_NINE);

	// Classify the byte; a digit's value is its low nibble
	always_comb begin
		item.is_digit = is_digit;
		item.digit    = is_digit ? reply_byte[3:0] : 4'd0;
		item.is_space = reply_byte == CH_SPACE;
		item.is_cr    = reply_byte == CH_CR;
		item.is_lf    = reply_byte == CH_LF;
		item.is_o     = reply_byte == CH_O;
		item.is_k     = reply_byte == CH_K;
		item.is_end   = end_of_reply;
	end

endmodule

/* hw/rtl/mlrp_back.sv */
// Back end: parse state machine, saturating decimal accumulators, record build.
// Depends on mlrp_pkg; writes up to two records per item into the record queue.
module mlrp_back import mlrp_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  item_t              item,
	input  logic               rec_room,
	input  logic [SLOTS_W-1:0] max_slots,
	output logic               item_take,
	output logic [1:0]         rec_wr_cnt,
	output rec_t               rec0,
	output rec_t               rec1
);

	localparam int VB = VALUE_BITS;

	phase_t        phase_q, phase_nx;
	logic [VB-1:0] acc_q, acc_nx;
	logic [VB-1:0] num_q, num_nx;
	logic [VB-1:0] sum_q, sum_nx;
	logic          ok_q, ok_nx;

	logic [VB+3:0] acc_wide;
	logic [VB-1:0] acc_dig;
	logic [VB:0]   sum_wide;
	logic [VB-1:0] sum_add;
	logic          slot_ok;
	logic          case_hit;
	rec_t          case_rec;
	rec_t          end_rec;

	// Keep the low result bits of a value, zero-extend a narrow one
	function automatic logic [OUT_W-1:0] to_out(input logic [VB-1:0] v);
		logic [OUT_W+VB-1:0] w;
		w = (OUT_W + VB)'(v);
		return w[OUT_W-1:0];
	endfunction

	// Multiply by ten and add the digit, saturate on overflow
	assign acc_wide = (VB + 4)'({acc_q, 3'b000}) + (VB + 4)'({acc_q, 1'b0})
		+ (VB + 4)'(item.digit);
	assign acc_dig  = (|acc_wide[VB+3:VB]) ? '1 : acc_wide[VB-1:0];

	// Saturating running total
	assign sum_wide = {1'b0, sum_q} + {1'b0, acc_q};
	assign sum_add  = sum_wide[VB] ? '1 : sum_wide[VB-1:0];

	// Slot number-1 below max_slots
	assign slot_ok = (num_q != '0) && (num_q <= VB'(max_slots));

	assign item_take = item_valid && rec_room;

	// Next phase, accumulators and records for the item at the queue head
	always_comb begin
		phase_nx = phase_q;
		acc_nx   = acc_q;
		num_nx   = num_q;
		sum_nx   = sum_q;
		ok_nx    = ok_q;
		case_hit = 1'b0;
		case_rec = '0;
		case_rec.found_ok    = ok_q;
		case_rec.last_record = !item.is_end;

		unique case (phase_q)
			PH_SEEK_O: begin
				if (item.is_o) begin
					phase_nx = PH_SEEK_K;
				end
			end
			PH_SEEK_K: begin
				if (item.is_k && !item.is_end) begin
					ok_nx    = 1'b1;
					acc_nx   = '0;
					phase_nx = PH_SKIP;
				end else begin
					phase_nx = item.is_o ? PH_SEEK_K : PH_SEEK_O;
				end
			end
			PH_SKIP: begin
				phase_nx = PH_COUNT;
			end
			PH_COUNT: begin
				priority if (item.is_digit) begin
					acc_nx = acc_dig;
				end else if (!item.is_space) begin
					case_hit            = 1'b1;
					case_rec.kind       = REC_COUNT;
					case_rec.value      = to_out(acc_q);
					case_rec.total_size = to_out(sum_q);
					acc_nx              = '0;
					phase_nx            = PH_SEEK_CR;
				end else begin
					// Skip spaces inside the count
				end
			end
			PH_SEEK_CR: begin
				if (item.is_cr) begin
					phase_nx = PH_SEEK_LF;
				end
			end
			PH_SEEK_LF: begin
				if (item.is_lf && !item.is_end) begin
					acc_nx   = '0;
					phase_nx = PH_NUMBER;
				end else begin
					phase_nx = item.is_cr ? PH_SEEK_LF : PH_SEEK_CR;
				end
			end
			PH_NUMBER: begin
				priority if (item.is_digit) begin
					acc_nx = acc_dig;
				end else if (item.is_space) begin
					num_nx   = acc_q;
					acc_nx   = '0;
					phase_nx = PH_SIZE;
				end else begin
					phase_nx = PH_DONE;
				end
			end
			PH_SIZE: begin
				priority if (item.is_digit) begin
					acc_nx = acc_dig;
				end else if (item.is_cr) begin
					phase_nx = PH_SIZE_LF;
				end else begin
					// Drop stray bytes inside the size
				end
			end
			PH_SIZE_LF: begin
				priority if (item.is_lf && !item.is_end) begin
					sum_nx              = sum_add;
					case_hit            = 1'b1;
					case_rec.kind       = REC_ENTRY;
					case_rec.msg_number = to_out(num_q);
					case_rec.value      = to_out(acc_q);
					case_rec.total_size = to_out(sum_add);
					case_rec.slot_valid = slot_ok;
					acc_nx              = '0;
					phase_nx            = PH_NUMBER;
				end else if (item.is_digit) begin
					acc_nx   = acc_dig;
					phase_nx = PH_SIZE;
				end else if (!item.is_cr) begin
					phase_nx = PH_SIZE;
				end else begin
					// Hold on a repeated CR
				end
			end
			default: begin
			end
		endcase

		// End record sees the state left by this byte, then rearm
		end_rec             = '0;
		end_rec.kind        = REC_END;
		end_rec.total_size  = to_out(sum_nx);
		end_rec.found_ok    = ok_nx;
		end_rec.last_record = 1'b1;

		if (item.is_end) begin
			phase_nx = PH_SEEK_O;
			acc_nx   = '0;
			num_nx   = '0;
			sum_nx   = '0;
			ok_nx    = 1'b0;
		end

		rec0       = case_hit ? case_rec : end_rec;
		rec1       = end_rec;
		rec_wr_cnt = item_take ? (2'(case_hit) + 2'(item.is_end)) : 2'd0;
	end

	// Hold parse state, advance it on each taken item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK_O;
			acc_q   <= '0;
			num_q   <= '0;
			sum_q   <= '0;
			ok_q    <= 1'b0;
		end else if (item_take) begin
			phase_q <= phase_nx;
			acc_q   <= acc_nx;
			num_q   <= num_nx;
			sum_q   <= sum_nx;
			ok_q    <= ok_nx;
		end
	end

endmodule

/* hw/rtl/mail_list_reply_parser_unit.sv */
// Top level of the mail LIST reply parser: byte queue in, record queue out.
// Depends on mlrp_pkg, mlrp_front, mlrp_fifo and mlrp_back.
//
//   channel   handshake              payload
//   bytes     push / full            reply_byte, end_of_reply
//   records   pop / empty            record_kind, msg_number, value,
//                                    total_size, slot_valid, found_ok, last_record
//   config    cfg_valid / cfg_ready  cfg_data (max_slots)
//
// One byte a cycle sustained while the record queue has room; a byte is classified
// on entry and parsed in the cycle after or later, at the head of the four-entry
// byte queue. A byte yielding a record plus the end record needs two pops, so the
// four-entry record queue sets the rate when such bytes follow closely.
// Reset clears the parse state, both queues and max_slots; no clearing pass.
module mail_list_reply_parser_unit import mlrp_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         reply_byte,
	input  logic               end_of_reply,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         record_kind,
	output logic [OUT_W-1:0]   msg_number,
	output logic [OUT_W-1:0]   value,
	output logic [OUT_W-1:0]   total_size,
	output logic               slot_valid,
	output logic               found_ok,
	output logic               last_record,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SLOTS_W-1:0] cfg_data
);

	localparam int ICW = $clog2(ITEM_DEPTH + 1);
	localparam int RCW = $clog2(REC_DEPTH + 1);

	logic [SLOTS_W-1:0] max_slots_q;
	item_t              item_in;
	item_t              item_head;
	logic [ICW-1:0]     item_count;
	logic               item_empty;
	logic               item_take;
	logic               push_ok;
	logic [RCW-1:0]     rec_count;
	logic               rec_room;
	logic [1:0]         rec_wr_cnt;
	rec_t               rec0;
	rec_t               rec1;
	rec_t               rec_head;
	logic               pop_ok;

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slots_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			max_slots_q <= cfg_data;
		end
	end

	// Classify incoming bytes
	mlrp_front u_front (
		.reply_byte  (reply_byte),
		.end_of_reply(end_of_reply),
		.item        (item_in)
	);

	assign full    = item_count == ICW'(ITEM_DEPTH);
	assign push_ok = push && !full;

	// Byte queue between front and back
	mlrp_fifo #(
		.entry_t(item_t),
		.DEPTH  (ITEM_DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cnt  ({1'b0, push_ok}),
		.wr_data0(item_in),
		.wr_data1(item_in),
		.rd_en   (item_take),
		.rd_data (item_head),
		.count   (item_count)
	);

	assign item_empty = item_count == '0;
	assign rec_room   = rec_count <= RCW'(REC_DEPTH - 2);

	// Parse bytes into records
	mlrp_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(!item_empty),
		.item      (item_head),
		.rec_room  (rec_room),
		.max_slots (max_slots_q),
		.item_take (item_take),
		.rec_wr_cnt(rec_wr_cnt),
		.rec0      (rec0),
		.rec1      (rec1)
	);

	// Record queue toward the consumer
	mlrp_fifo #(
		.entry_t(rec_t),
		.DEPTH  (REC_DEPTH)
	) u_rec_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cnt  (rec_wr_cnt),
		.wr_data0(rec0),
		.wr_data1(rec1),
		.rd_en   (pop_ok),
		.rd_data (rec_head),
		.count   (rec_count)
	);

	assign empty  = rec_count == '0;
	assign pop_ok = pop && !empty;

	assign record_kind = rec_head.kind;
	assign msg_number  = rec_head.msg_number;
	assign value       = rec_head.value;
	assign total_size  = rec_head.total_size;
	assign slot_valid  = rec_head.slot_valid;
	assign found_ok    = rec_head.found_ok;
	assign last_record = rec_head.last_record;

	// Record queue never overflows
	a_rec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rec_count <= RCW'(REC_DEPTH))
		else $error("record queue overflow");

	// A final byte always leaves at least its end record
	a_end_rec: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && item_head.is_end) |-> (rec_wr_cnt != 2'd0))
		else $error("final byte produced no record");

	// An accepted byte is waiting in the byte queue on the next cycle
	a_push_held: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> !item_empty)
		else $error("accepted byte lost");

endmodule

/* tb/mail_list_reply_parser_unit_test.sv */
// Self-checking testbench of mail_list_reply_parser_unit: replies go in one byte per item,
// records are checked against a parser model kept here, under random idling on both sides.
// Depends on mlrp_pkg and mail_list_reply_parser_unit; reads no file.
module mail_list_reply_parser_unit_test;
	import mlrp_pkg::*;

	localparam longint unsigned VMAX = 64'hFFFF_FFFF;
	localparam int PHASE_ITEMS  = 265;
	localparam int QUIET_CYCLES = 16;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASES       = 7;

	typedef struct {
		logic [7:0] b;
		logic       eor;
		logic       typed;
		rec_t       want;
	} script_row_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         reply_byte;
	logic               end_of_reply;
	logic               empty;
	logic               pop;
	logic [1:0]         record_kind;
	logic [OUT_W-1:0]   msg_number;
	logic [OUT_W-1:0]   value;
	logic [OUT_W-1:0]   total_size;
	logic               slot_valid;
	logic               found_ok;
	logic               last_record;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [SLOTS_W-1:0] cfg_data;

	// Parser model state and its copy of max_slots
	phase_t             parse_ph;
	longint unsigned    digit_acc;
	longint unsigned    entry_num;
	longint unsigned    size_total;
	logic               ok_flag;
	logic [SLOTS_W-1:0] slot_limit;

	rec_t        pending_records[$];
	logic [7:0]  reply_q[$];
	script_row_t script[$];
	int          errors;
	int          idle_cycles;
	int          gap_pct;
	logic        cur_typed;
	rec_t        cur_want;

	mail_list_reply_parser_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.reply_byte     (reply_byte),
		.end_of_reply   (end_of_reply),
		.empty          (empty),
		.pop            (pop),
		.record_kind    (record_kind),
		.msg_number     (msg_number),
		.value          (value),
		.total_size     (total_size),
		.slot_valid     (slot_valid),
		.found_ok       (found_ok),
		.last_record    (last_record),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Decimal accumulate, held at the 32-bit ceiling
	function automatic longint unsigned add_digit(longint unsigned acc, logic [7:0] b);
		longint unsigned d;
		d = b;
		d = d - CH_ZERO;
		if (acc > (VMAX - d) / 10)
			return VMAX;
		return acc * 10 + d;
	endfunction

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
		if (b > VMAX - a)
			return VMAX;
		return a + b;
	endfunction

	function automatic rec_t rec_of(rec_kind_t k, longint unsigned num, longint unsigned val,
			longint unsigned tot, logic valid, logic ok, logic last);
		rec_t r;
		r.kind        = k;
		r.msg_number  = num[OUT_W-1:0];
		r.value       = val[OUT_W-1:0];
		r.total_size  = tot[OUT_W-1:0];
		r.slot_valid  = valid;
		r.found_ok    = ok;
		r.last_record = last;
		return r;
	endfunction

	function automatic void rearm();
		parse_ph   = PH_SEEK_O;
		digit_acc  = 0;
		entry_num  = 0;
		size_total = 0;
		ok_flag    = 1'b0;
	endfunction

	// Advance the parser model by one byte; return the number of records it yields
	function automatic int parse_byte(input logic [7:0] b, input logic eor,
			output rec_t first, output rec_t second);
		logic dig;
		logic valid;
		int   n;
		dig    = (b >= CH_ZERO) && (b <= CH_NINE);
		n      = 0;
		first  = '0;
		second = '0;
		case (parse_ph)
		PH_SEEK_O: begin
			if (b == CH_O)
				parse_ph = PH_SEEK_K;
		end
		PH_SEEK_K: begin
			if (b == CH_K && !eor) begin
				ok_flag   = 1'b1;
				digit_acc = 0;
				parse_ph  = PH_SKIP;
			end else begin
				parse_ph = (b == CH_O) ? PH_SEEK_K : PH_SEEK_O;
			end
		end
		PH_SKIP: begin
			parse_ph = PH_COUNT;
		end
		PH_COUNT: begin
			if (dig) begin
				digit_acc = add_digit(digit_acc, b);
			end else if (b != CH_SPACE) begin
				first     = rec_of(REC_COUNT, 0, digit_acc, size_total, 1'b0, ok_flag, 1'b0);
				n         = 1;
				digit_acc = 0;
				parse_ph  = PH_SEEK_CR;
			end
		end
		PH_SEEK_CR: begin
			if (b == CH_CR)
				parse_ph = PH_SEEK_LF;
		end
		PH_SEEK_LF: begin
			if (b == CH_LF && !eor) begin
				digit_acc = 0;
				parse_ph  = PH_NUMBER;
			end else begin
				parse_ph = (b == CH_CR) ? PH_SEEK_LF : PH_SEEK_CR;
			end
		end
		PH_NUMBER: begin
			if (dig) begin
				digit_acc = add_digit(digit_acc, b);
			end else if (b == CH_SPACE) begin
				entry_num = digit_acc;
				digit_acc = 0;
				parse_ph  = PH_SIZE;
			end else begin
				parse_ph = PH_DONE;
			end
		end
		PH_SIZE: begin
			if (dig)
				digit_acc = add_digit(digit_acc, b);
			else if (b == CH_CR)
				parse_ph = PH_SIZE_LF;
		end
		PH_SIZE_LF: begin
			if (b == CH_LF && !eor) begin
				valid      = (entry_num >= 1) && (entry_num - 1 < slot_limit);
				size_total = sat_sum(size_total, digit_acc);
				first      = rec_of(REC_ENTRY, entry_num, digit_acc, size_total, valid,
					ok_flag, 1'b0);
				n          = 1;
				digit_acc  = 0;
				parse_ph   = PH_NUMBER;
			end else if (dig) begin
				digit_acc = add_digit(digit_acc, b);
				parse_ph  = PH_SIZE;
			end else if (b != CH_CR) begin
				parse_ph = PH_SIZE;
			end
		end
		default: begin
		end
		endcase

		// Mark the last record of this byte; the end record closes the reply
		if (n == 1)
			first.last_record = !eor;
		if (eor) begin
			if (n == 1)
				second = rec_of(REC_END, 0, 0, size_total, 1'b0, ok_flag, 1'b1);
			else
				first = rec_of(REC_END, 0, 0, size_total, 1'b0, ok_flag, 1'b1);
			n = n + 1;
			rearm();
		end
		return n;
	endfunction

	task automatic report_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors = errors + 1;
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		end
	endtask

	// Predict on every accepted item, check every accepted record, watch for stalls
	always @(posedge clk) begin : monitor
		rec_t first;
		rec_t second;
		rec_t head;
		int   n;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_records.size() == 0) begin
					errors = errors + 1;
					$display("%0t: record kind %0d arrived, expected none, value %0d",
						$time, record_kind, value);
				end else begin
					head = pending_records.pop_front();
					report_field("record_kind", head.kind, record_kind);
					report_field("msg_number", head.msg_number, msg_number);
					report_field("value", head.value, value);
					report_field("total_size", head.total_size, total_size);
					report_field("slot_valid", head.slot_valid, slot_valid);
					report_field("found_ok", head.found_ok, found_ok);
					report_field("last_record", head.last_record, last_record);
				end
			end
			if (push && !full) begin
				n = parse_byte(reply_byte, end_of_reply, first, second);
				if (cur_typed) begin
					pending_records.push_back(cur_want);
				end else begin
					if (n > 0)
						pending_records.push_back(first);
					if (n > 1)
						pending_records.push_back(second);
				end
			end
			if (cfg_valid && cfg_ready)
				slot_limit = cfg_data;
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Pop in bursts with random stalls, now and then a long steady stretch
	initial begin : drain_side
		int run;
		int stall;
		int r;
		pop = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			pop = 1'b1;
			run = ($urandom_range(0, 99) < 6) ? 80 : $urandom_range(1, 8);
			repeat (run) @(negedge clk);
			r = $urandom_range(0, 99);
			if (r < 40)
				stall = 0;
			else if (r < 75)
				stall = $urandom_range(1, 3);
			else if (r < 93)
				stall = $urandom_range(4, 12);
			else
				stall = $urandom_range(20, 60);
			if (stall > 0) begin
				pop = 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 99) >= gap_pct)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 94)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one item after a random gap; return at the falling edge after it is taken
	task automatic send_byte(input logic [7:0] b, input logic eor, input logic typed,
			input rec_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push         = 1'b1;
		reply_byte   = b;
		end_of_reply = eor;
		cur_typed    = typed;
		cur_want     = want;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	// Hold off until every record has come and the byte queue has run dry
	task automatic wait_drained();
		push = 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_slots(input logic [SLOTS_W-1:0] v);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] noisy_byte();
		case ($urandom_range(0, 7))
		0: return CH_O;
		1: return CH_K;
		2: return CH_CR;
		3: return CH_LF;
		4: return CH_SPACE;
		5: return CH_ZERO + 8'($urandom_range(0, 9));
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] count_stop();
		logic [7:0] b;
		if ($urandom_range(0, 1) == 0)
			return "m";
		do
			b = 8'($urandom_range(0, 255));
		while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE);
		return b;
	endfunction

	task automatic put_number(input longint unsigned v);
		logic [7:0] digs[$];
		do begin
			digs.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[i])
			reply_q.push_back(digs[i]);
	endtask

	// Digit run too long for 32 bits
	task automatic put_long_run(input int len);
		reply_q.push_back(CH_NINE);
		repeat (len - 1) reply_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic put_value(input int spread);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			put_number($urandom_range(0, spread));
		else if (r < 84)
			put_number($urandom);
		else if (r < 92)
			put_number(VMAX - 1 + $urandom_range(0, 2));
		else
			put_long_run($urandom_range(10, 14));
	endtask

	// Entry numbers cluster around the slot boundary
	task automatic put_entry_number();
		case ($urandom_range(0, 9))
		0: put_number(0);
		1: put_number({48'd0, slot_limit});
		2: put_number({48'd0, slot_limit} + 64'd1);
		3: put_value(100000);
		default: put_number($urandom_range(1, 12));
		endcase
	endtask

	// Build one reply: mostly well formed, some cut short, some plain noise
	task automatic compose_reply();
		int kind;
		int lines;
		int trim;
		reply_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			repeat ($urandom_range(1, 12)) reply_q.push_back(noisy_byte());
		end else begin
			if ($urandom_range(0, 9) == 0)
				reply_q.push_back(noisy_byte());
			reply_q.push_back("+");
			reply_q.push_back(CH_O);
			reply_q.push_back(CH_K);
			reply_q.push_back(($urandom_range(0, 4) == 0) ? noisy_byte() : CH_SPACE);
			put_value(60);
			if ($urandom_range(0, 5) == 0) begin
				reply_q.push_back(CH_SPACE);
				reply_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			reply_q.push_back(CH_SPACE);
			reply_q.push_back(count_stop());
			if ($urandom_range(0, 5) == 0)
				reply_q.push_back(CH_CR);
			reply_q.push_back(CH_CR);
			reply_q.push_back(CH_LF);
			lines = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
			repeat (lines) begin
				put_entry_number();
				reply_q.push_back(CH_SPACE);
				put_value(99999);
				if ($urandom_range(0, 9) == 0)
					reply_q.push_back(noisy_byte());
				if ($urandom_range(0, 19) == 0) begin
					reply_q.push_back(CH_CR);
					reply_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				reply_q.push_back(CH_CR);
				reply_q.push_back(CH_LF);
			end
			if ($urandom_range(0, 4) != 0) begin
				reply_q.push_back(".");
				reply_q.push_back(CH_CR);
				reply_q.push_back(CH_LF);
			end
			if (kind < 30) begin
				trim = $urandom_range(1, reply_q.size());
				while (reply_q.size() > trim)
					void'(reply_q.pop_back());
			end
		end
	endtask

	function automatic script_row_t step_row(logic [7:0] b, logic eor);
		script_row_t row;
		row.b     = b;
		row.eor   = eor;
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic script_row_t checked_row(logic [7:0] b, logic eor, rec_t want);
		script_row_t row;
		row       = step_row(b, eor);
		row.typed = 1'b1;
		row.want  = want;
		return row;
	endfunction

	initial begin : stimulus
		logic [SLOTS_W-1:0] slot_plan[PHASES];
		int sent;
		push         = 1'b0;
		reply_byte   = 8'd0;
		end_of_reply = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		cur_typed    = 1'b0;
		cur_want     = '0;
		errors       = 0;
		idle_cycles  = 0;
		gap_pct      = 30;
		slot_limit   = '0;
		rearm();
		arst_n = 1'b0;

		// Lone final byte, OK split by the final flag, then a short reply with max_slots 0
		script.push_back(checked_row("X", 1'b1,
			rec_of(REC_END, 0, 0, 0, 1'b0, 1'b0, 1'b1)));
		script.push_back(step_row(CH_O, 1'b0));
		script.push_back(checked_row(CH_K, 1'b1,
			rec_of(REC_END, 0, 0, 0, 1'b0, 1'b0, 1'b1)));
		script.push_back(step_row(CH_O, 1'b0));
		script.push_back(step_row(CH_O, 1'b0));
		script.push_back(step_row(CH_K, 1'b0));
		script.push_back(step_row(8'hFF, 1'b0));
		script.push_back(step_row("4", 1'b0));
		script.push_back(step_row(CH_SPACE, 1'b0));
		script.push_back(step_row("2", 1'b0));
		script.push_back(checked_row(8'h00, 1'b0,
			rec_of(REC_COUNT, 0, 42, 0, 1'b0, 1'b1, 1'b1)));
		script.push_back(step_row(CH_CR, 1'b0));
		script.push_back(step_row(CH_CR, 1'b0));
		script.push_back(step_row(CH_LF, 1'b0));
		script.push_back(step_row("1", 1'b0));
		script.push_back(step_row(CH_SPACE, 1'b0));
		script.push_back(step_row("9", 1'b0));
		script.push_back(step_row("x", 1'b0));
		script.push_back(step_row(CH_CR, 1'b0));
		script.push_back(step_row("5", 1'b0));
		script.push_back(step_row(CH_CR, 1'b0));
		script.push_back(step_row(CH_LF, 1'b0));
		script.push_back(step_row("Z", 1'b0));
		script.push_back(checked_row(8'h80, 1'b1,
			rec_of(REC_END, 0, 0, 95, 1'b0, 1'b1, 1'b1)));

		slot_plan = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(2, 65533)), 16'hFFFE,
			16'd3, 16'd7};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed script
		foreach (script[i])
			send_byte(script[i].b, script[i].eor, script[i].typed, script[i].want);
		wait_drained();

		// Random replies, one max_slots setting per phase
		for (int p = 0; p < PHASES; p++) begin
			write_slots(slot_plan[p]);
			gap_pct = (p == 2) ? 0 : 30;
			sent    = 0;
			while (sent < PHASE_ITEMS) begin
				compose_reply();
				if ($urandom_range(0, 19) == 0)
					wait_drained();
				foreach (reply_q[i])
					send_byte(reply_q[i], i == reply_q.size() - 1, 1'b0, '0);
				sent = sent + reply_q.size();
			end
			wait_drained();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
